FILE: hw/rtl/scba_pkg.sv
// Shared types and constants of the size-class block allocator.
// Used by every module under hw/rtl but scba_ram; depends on nothing.
`default_nettype none

package scba_pkg;

  // default geometry (handed down as module parameters)
  localparam int NUM_CLASSES_DEF = 64;
  localparam int ALIGN_BYTES_DEF = 8;
  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int NUM_CHUNKS_DEF  = 64;

  // fixed field widths
  localparam int OPC_W     = 2;
  localparam int BYTES_W   = 16;
  localparam int ADDR_W    = 18;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 7;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 24;

  // class index field, wide enough for the largest class count
  localparam int CLS_W = 8;

  localparam int QDEPTH = 2;

  localparam logic [CFG_W-1:0] CHUNK_LIMIT_RST = 7'd64;

  typedef enum logic [OPC_W-1:0] {
    OPC_ALLOC   = 2'd0,
    OPC_FREE    = 2'd1,
    OPC_COLLECT = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE      = 2'd0,
    STS_TOO_LARGE = 2'd1,
    STS_NO_CHUNK  = 2'd2
  } status_e;

  // what the back end has to do with a beat
  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_BIG,
    KIND_ALLOC,
    KIND_FREE,
    KIND_COLLECT
  } kind_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_EXEC,
    BS_LINK
  } bstate_e;

  typedef struct packed {
    kind_e             kind;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/scba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/scba_front.sv
// Front end: takes input beats and decodes them into back-end commands.
// Depends on scba_pkg.
`default_nettype none

module scba_front #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int ALIGN_BYTES = scba_pkg::ALIGN_BYTES_DEF,
  parameter int CHUNK_BYTES = scba_pkg::CHUNK_BYTES_DEF,
  parameter int NUM_CHUNKS  = scba_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] request_bytes, [33:16] free_address, rest zero
  input  wire logic [scba_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [scba_pkg::OPC_W-1:0]     s_axis_tuser_i,
  input  wire logic                           q_ready_i,
  output scba_pkg::cmd_beat_t                 q_push_o
);

  localparam int AL          = $clog2(ALIGN_BYTES);
  localparam int SMALL_LIMIT = NUM_CLASSES * ALIGN_BYTES;
  localparam int HEAP_BYTES  = NUM_CHUNKS * CHUNK_BYTES;

  logic [scba_pkg::BYTES_W-1:0] bytes;
  logic [scba_pkg::ADDR_W-1:0]  addr;
  logic                         too_large;
  logic                         in_heap;
  logic [scba_pkg::CLS_W-1:0]   cls;
  scba_pkg::kind_e              kind;

  assign bytes = s_axis_tdata_i[scba_pkg::BYTES_W-1:0];
  assign addr  = s_axis_tdata_i[scba_pkg::BYTES_W+scba_pkg::ADDR_W-1:scba_pkg::BYTES_W];

  assign too_large = 32'(bytes) > SMALL_LIMIT;
  assign in_heap   = 32'(addr) < HEAP_BYTES;
  // size zero shares class 0 with the smallest blocks
  assign cls = (bytes == '0) ? '0 : scba_pkg::CLS_W'((bytes - 16'd1) >> AL);

  always_comb begin
    unique case (scba_pkg::opcode_e'(s_axis_tuser_i))
      scba_pkg::OPC_ALLOC:   kind = too_large ? scba_pkg::KIND_BIG : scba_pkg::KIND_ALLOC;
      scba_pkg::OPC_FREE: begin
        if (too_large) begin
          kind = scba_pkg::KIND_BIG;
        end else if (in_heap) begin
          kind = scba_pkg::KIND_FREE;
        end else begin
          kind = scba_pkg::KIND_NOP;
        end
      end
      scba_pkg::OPC_COLLECT: kind = scba_pkg::KIND_COLLECT;
      default:               kind = scba_pkg::KIND_NOP;
    endcase
  end

  assign q_push_o.valid    = s_axis_tvalid_i;
  assign q_push_o.cmd.kind = kind;
  assign q_push_o.cmd.cls  = cls;
  assign q_push_o.cmd.addr = addr;
  assign s_axis_tready_o   = q_ready_i;

endmodule

`default_nettype wire

FILE: hw/rtl/scba_cmd_queue.sv
// Short command queue between front end and back end.
// Depends on scba_pkg.
`default_nettype none

module scba_cmd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire scba_pkg::cmd_beat_t push_i,
  output logic                     push_ready_o,
  output scba_pkg::cmd_beat_t      head_o,
  input  wire logic                pop_i
);

  localparam int QAW = $clog2(scba_pkg::QDEPTH);
  localparam int CW  = $clog2(scba_pkg::QDEPTH + 1);

  scba_pkg::cmd_t slot_q [scba_pkg::QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push;

  assign push_ready_o = cnt_q != CW'(scba_pkg::QDEPTH);
  assign push         = push_i.valid && push_ready_o;
  assign head_o.valid = cnt_q != '0;
  assign head_o.cmd   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QAW'(scba_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QAW'(scba_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/scba_back.sv
// Back end: sequencer over the list-head, cursor and link memories, result register.
// Depends on scba_pkg and scba_ram.
`default_nettype none

module scba_back #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int ALIGN_BYTES = scba_pkg::ALIGN_BYTES_DEF,
  parameter int CHUNK_BYTES = scba_pkg::CHUNK_BYTES_DEF,
  parameter int NUM_CHUNKS  = scba_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire scba_pkg::cmd_beat_t            q_head_i,
  output logic                                q_pop_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic      [scba_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic      [scba_pkg::STATUS_W-1:0]  m_axis_tuser_o
);

  localparam int AL   = $clog2(ALIGN_BYTES);
  localparam int CG   = CHUNK_BYTES / ALIGN_BYTES;   // granules per chunk
  localparam int CGL  = $clog2(CG);
  localparam int GRAN = NUM_CHUNKS * CG;
  localparam int GW   = $clog2(GRAN);
  localparam int CLW  = $clog2(NUM_CLASSES);
  localparam int BGW  = CLW + 1;
  localparam int SW   = ((GW > BGW) ? GW : BGW) + 2;
  localparam int CUW  = $clog2(NUM_CHUNKS + 1);

  function automatic logic [scba_pkg::ADDR_W-1:0] gran_to_addr(logic [GW-1:0] g);
    return scba_pkg::ADDR_W'(32'(g) << AL);
  endfunction

  scba_pkg::bstate_e state_q, state_d;
  scba_pkg::cmd_t    cur_q, cur_d;

  logic [NUM_CLASSES-1:0]       hvld_q, hvld_d;
  logic [NUM_CLASSES-1:0]       cvld_q, cvld_d;
  logic [CUW-1:0]               used_q, used_d;
  logic [scba_pkg::CFG_W-1:0]   limit_q;

  logic                         out_vld_q, out_vld_d;
  scba_pkg::status_e            out_sts_q, out_sts_d;
  logic [scba_pkg::ADDR_W-1:0]  out_addr_q, out_addr_d;

  logic                         res_vld;
  scba_pkg::status_e            res_sts;
  logic [scba_pkg::ADDR_W-1:0]  res_addr;

  logic           head_we, cur_we, link_we;
  logic [CLW-1:0] head_waddr, head_raddr, cur_waddr, cur_raddr;
  logic [GW-1:0]  head_wdata, head_rdata, cur_wdata, cur_rdata;
  logic [GW-1:0]  link_waddr, link_raddr;
  logic [GW:0]    link_wdata, link_rdata;

  logic           pop_ok;
  logic [CLW-1:0] cls;
  logic [BGW-1:0] bg;
  logic           hv, cv;
  logic [GW-1:0]  fgran;
  logic           lim_hit, blk_too_big, carve_last;
  logic [GW-1:0]  carve_a, carve_next;

  // one command in flight; the result slot is free by the time it finishes
  assign pop_ok  = (state_q == scba_pkg::BS_IDLE) && q_head_i.valid &&
                   (!out_vld_q || m_axis_tready_i);
  assign q_pop_o = pop_ok;
  assign cur_d   = pop_ok ? q_head_i.cmd : cur_q;

  assign head_raddr = CLW'(q_head_i.cmd.cls);
  assign cur_raddr  = CLW'(q_head_i.cmd.cls);
  assign link_raddr = head_rdata;

  assign cls   = CLW'(cur_q.cls);
  assign bg    = BGW'(cls) + BGW'(1);
  assign hv    = hvld_q[cls];
  assign cv    = cvld_q[cls];
  assign fgran = GW'(cur_q.addr >> AL);

  assign lim_hit     = (32'(used_q) >= 32'(limit_q)) || (32'(used_q) >= NUM_CHUNKS);
  assign blk_too_big = SW'(bg) > SW'(CG);
  // no current chunk: start at the base of the next unused one
  assign carve_a     = cv ? cur_rdata : (GW'(used_q) << CGL);
  assign carve_next  = carve_a + GW'(bg);
  // retire the cursor once a further block would not fit in the chunk
  assign carve_last  = (SW'(carve_a[CGL-1:0]) + (SW'(bg) << 1)) > SW'(CG);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scba_pkg::BS_IDLE: begin
        if (pop_ok) begin
          state_d = scba_pkg::BS_EXEC;
        end
      end
      scba_pkg::BS_EXEC: begin
        if (cur_q.kind == scba_pkg::KIND_ALLOC && hv) begin
          state_d = scba_pkg::BS_LINK;
        end else begin
          state_d = scba_pkg::BS_IDLE;
        end
      end
      scba_pkg::BS_LINK: state_d = scba_pkg::BS_IDLE;
      default:           state_d = scba_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    head_we    = 1'b0;
    head_waddr = cls;
    head_wdata = fgran;
    cur_we     = 1'b0;
    cur_waddr  = cls;
    cur_wdata  = carve_next;
    link_we    = 1'b0;
    link_waddr = fgran;
    link_wdata = hv ? {1'b1, head_rdata} : '0;
    hvld_d     = hvld_q;
    cvld_d     = cvld_q;
    used_d     = used_q;
    res_vld    = 1'b0;
    res_sts    = scba_pkg::STS_DONE;
    res_addr   = '0;
    unique case (state_q)
      scba_pkg::BS_EXEC: begin
        res_vld = 1'b1;
        unique case (cur_q.kind)
          scba_pkg::KIND_BIG: res_sts = scba_pkg::STS_TOO_LARGE;
          scba_pkg::KIND_COLLECT: begin
            hvld_d = '0;
            cvld_d = '0;
            used_d = '0;
          end
          scba_pkg::KIND_FREE: begin
            link_we     = 1'b1;
            head_we     = 1'b1;
            hvld_d[cls] = 1'b1;
          end
          scba_pkg::KIND_ALLOC: begin
            if (hv) begin
              res_addr = gran_to_addr(head_rdata);
            end else if (!cv && (blk_too_big || lim_hit)) begin
              res_sts = scba_pkg::STS_NO_CHUNK;
            end else begin
              res_addr = gran_to_addr(carve_a);
              if (!cv) begin
                used_d = used_q + 1'b1;
              end
              if (carve_last) begin
                cvld_d[cls] = 1'b0;
              end else begin
                cvld_d[cls] = 1'b1;
                cur_we      = 1'b1;
              end
            end
          end
          default: res_sts = scba_pkg::STS_DONE;
        endcase
      end
      scba_pkg::BS_LINK: begin
        // popped head's link word is now out of the link memory
        head_we     = 1'b1;
        head_wdata  = link_rdata[GW-1:0];
        hvld_d[cls] = link_rdata[GW];
      end
      default: res_vld = 1'b0;
    endcase
  end

  assign out_vld_d  = res_vld || (out_vld_q && !m_axis_tready_i);
  assign out_sts_d  = res_vld ? res_sts : out_sts_q;
  assign out_addr_d = res_vld ? res_addr : out_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scba_pkg::BS_IDLE;
      hvld_q    <= '0;
      cvld_q    <= '0;
      used_q    <= '0;
      limit_q   <= scba_pkg::CHUNK_LIMIT_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      hvld_q    <= hvld_d;
      cvld_q    <= cvld_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_sts_q  <= out_sts_d;
    out_addr_q <= out_addr_d;
  end

  scba_ram #(.WIDTH(GW), .DEPTH(NUM_CLASSES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  scba_ram #(.WIDTH(GW), .DEPTH(NUM_CLASSES)) u_cursor_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  scba_ram #(.WIDTH(GW + 1), .DEPTH(GRAN)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(scba_pkg::M_TDATA_W - scba_pkg::ADDR_W){1'b0}}, out_addr_q};
  assign m_axis_tuser_o  = out_sts_q;

endmodule

`default_nettype wire

FILE: hw/rtl/size_class_block_allocator.sv
// A beat goes through the command queue and the EXEC state into the result register.
// One beat at a time in the back end; a free-list allocation adds the BS_LINK state,
//   since the list head and then its link word come out of registered-read RAMs.
// The 2-entry command queue takes beats until full while a result waits downstream.
// Reset: all lists and cursors empty and chunk count zero at once (valid flops),
//   chunk_limit back to 64; no clearing pass, the link memory is not cleared.
`default_nettype none

module size_class_block_allocator #(
  parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
  parameter int ALIGN_BYTES = scba_pkg::ALIGN_BYTES_DEF,
  parameter int CHUNK_BYTES = scba_pkg::CHUNK_BYTES_DEF,
  parameter int NUM_CHUNKS  = scba_pkg::NUM_CHUNKS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [scba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] request_bytes, [33:16] free_address, [39:34] zero
  input  wire logic [scba_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] opcode
  input  wire logic [scba_pkg::OPC_W-1:0]     s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [17:0] block_address, [23:18] zero
  output logic      [scba_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic      [scba_pkg::STATUS_W-1:0]  m_axis_tuser_o
);

  scba_pkg::cmd_beat_t q_push;
  scba_pkg::cmd_beat_t q_head;
  logic                q_ready;
  logic                q_pop;

  scba_front #(
    .NUM_CLASSES (NUM_CLASSES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES),
    .NUM_CHUNKS  (NUM_CHUNKS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push)
  );

  scba_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_ready_o (q_ready),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  scba_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .ALIGN_BYTES (ALIGN_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES),
    .NUM_CHUNKS  (NUM_CHUNKS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // a command starts only when the result slot is free or draining
  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("command started while result slot busy");

  // back end works on one command at a time
  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("back-to-back command pops");

  // every new result beat traces back to a popped command
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(q_pop, 2))
    else $error("result beat without a command");

endmodule

`default_nettype wire

FILE: tb/sv/tb_size_class_block_allocator.sv
// Self-checking bench for size_class_block_allocator: drives allocate, free and
// collect beats with random idling, predicts each result and checks it on arrival.
// Depends on scba_pkg and the allocator RTL only.
`default_nettype none

module tb_size_class_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPC_W     = scba_pkg::OPC_W;
  localparam int BYTES_W   = scba_pkg::BYTES_W;
  localparam int ADDR_W    = scba_pkg::ADDR_W;
  localparam int CFG_W     = scba_pkg::CFG_W;
  localparam int S_TDATA_W = scba_pkg::S_TDATA_W;
  localparam int M_TDATA_W = scba_pkg::M_TDATA_W;
  localparam int STATUS_W  = scba_pkg::STATUS_W;

  localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;
  localparam int GRAIN       = scba_pkg::ALIGN_BYTES_DEF;
  localparam int CLASS_CNT   = scba_pkg::NUM_CLASSES_DEF;
  localparam int CHUNK_SZ    = scba_pkg::CHUNK_BYTES_DEF;
  localparam int CHUNK_CNT   = scba_pkg::NUM_CHUNKS_DEF;
  localparam int SMALL_MAX   = CLASS_CNT * GRAIN;
  localparam int GRAIN_CNT   = CHUNK_CNT * CHUNK_SZ / GRAIN;
  localparam int GRAIN_W     = $clog2(GRAIN_CNT);
  localparam int GRAIN_SHIFT = $clog2(GRAIN);
  localparam int CURSOR_W    = ADDR_W + 1;

  typedef struct {
    scba_pkg::status_e sts;
    logic [ADDR_W-1:0] addr;
  } outcome_t;

  typedef struct {
    logic [BYTES_W-1:0] nbytes;
    logic [ADDR_W-1:0]  addr;
  } live_block_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata_i     = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i  = '0;
  logic [OPC_W-1:0]     s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]  m_axis_tuser_o;

  // predicted allocator state
  bit                   head_ok   [CLASS_CNT];
  bit [GRAIN_W-1:0]     head_gran [CLASS_CNT];
  bit                   link_ok   [GRAIN_CNT];
  bit [GRAIN_W-1:0]     link_gran [GRAIN_CNT];
  bit                   cursor_ok [CLASS_CNT];
  bit [ADDR_W:0]        cursor_at [CLASS_CNT];
  int unsigned          chunks_taken;
  logic [CFG_W-1:0]     chunk_cap = scba_pkg::CHUNK_LIMIT_RST;

  outcome_t             alloc_results_q [$];
  live_block_t          live_blocks [$];
  outcome_t             arrived_want;
  int                   mismatch_count = 0;
  int                   src_idle_pct   = 0;
  int                   sink_stall_pct = 0;

  size_class_block_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("%0t: timeout, %0d results still pending", $time, alloc_results_q.size());
    $display("tb_size_class_block_allocator: errors");
    $finish;
  end

  function automatic void drop_lists_and_chunks();
    for (int c = 0; c < CLASS_CNT; c++) begin
      head_ok[c]   = 1'b0;
      cursor_ok[c] = 1'b0;
    end
    chunks_taken = 0;
  endfunction

  // Applies one beat to the predicted state and returns the result it gives.
  function automatic outcome_t apply_heap_op(input logic [OPC_W-1:0] op,
                                             input logic [BYTES_W-1:0] nbytes,
                                             input logic [ADDR_W-1:0] faddr);
    outcome_t         res;
    int unsigned      cls;
    int unsigned      blk;
    int unsigned      lim;
    int unsigned      chunk_end;
    bit [GRAIN_W-1:0] g;
    bit [ADDR_W:0]    a;
    res.sts  = scba_pkg::STS_DONE;
    res.addr = '0;
    if (op == scba_pkg::OPC_COLLECT) begin
      drop_lists_and_chunks();
      return res;
    end
    if (op == OPC_UNUSED)
      return res;
    if (nbytes > SMALL_MAX) begin
      res.sts = scba_pkg::STS_TOO_LARGE;
      return res;
    end
    cls = (nbytes == 0) ? 0 : (nbytes - 1) / GRAIN;
    blk = (cls + 1) * GRAIN;
    if (op == scba_pkg::OPC_FREE) begin
      g = faddr[ADDR_W-1:GRAIN_SHIFT];
      link_ok[g]     = head_ok[cls];
      link_gran[g]   = head_gran[cls];
      head_gran[cls] = g;
      head_ok[cls]   = 1'b1;
      return res;
    end
    // allocate: free list first (LIFO)
    if (head_ok[cls]) begin
      g = head_gran[cls];
      res.addr       = {g, {GRAIN_SHIFT{1'b0}}};
      head_ok[cls]   = link_ok[g];
      head_gran[cls] = link_gran[g];
      return res;
    end
    if (!cursor_ok[cls]) begin
      lim = (chunk_cap > CHUNK_CNT) ? CHUNK_CNT : chunk_cap;
      if (blk > CHUNK_SZ || chunks_taken >= lim) begin
        res.sts = scba_pkg::STS_NO_CHUNK;
        return res;
      end
      cursor_at[cls] = CURSOR_W'(chunks_taken * CHUNK_SZ);
      cursor_ok[cls] = 1'b1;
      chunks_taken++;
    end
    a = cursor_at[cls];
    res.addr  = a[ADDR_W-1:0];
    chunk_end = a - (a % CHUNK_SZ) + CHUNK_SZ;
    if (a + 2 * blk > chunk_end)
      cursor_ok[cls] = 1'b0;
    else
      cursor_at[cls] = CURSOR_W'(a + blk);
    return res;
  endfunction

  // One beat on the request side; valid is left high after the handshake so
  // that back-to-back beats go out with no idle gap between them.
  task automatic issue_request(input logic [OPC_W-1:0] op, input logic [BYTES_W-1:0] nbytes,
                               input logic [ADDR_W-1:0] faddr);
    outcome_t    res;
    live_block_t blk;
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_TDATA_W - ADDR_W - BYTES_W){1'b0}}, faddr, nbytes};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    res = apply_heap_op(op, nbytes, faddr);
    alloc_results_q.push_back(res);
    if (op == scba_pkg::OPC_COLLECT) begin
      live_blocks.delete();
    end else if (op == scba_pkg::OPC_ALLOC && res.sts == scba_pkg::STS_DONE &&
                 nbytes <= SMALL_MAX) begin
      blk.nbytes = nbytes;
      blk.addr   = res.addr;
      live_blocks.push_back(blk);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (alloc_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_chunk_limit(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chunk_cap = value;
  endtask

  function automatic logic [BYTES_W-1:0] bytes_of_class(input int unsigned cls);
    if (cls == 0)
      return BYTES_W'($urandom_range(0, GRAIN));
    return BYTES_W'(cls * GRAIN + $urandom_range(1, GRAIN));
  endfunction

  // mostly a few busy classes so lists get reused, the rest spread wide
  function automatic logic [BYTES_W-1:0] pick_size();
    if ($urandom_range(99) < 50)
      return bytes_of_class($urandom_range(0, 3));
    return bytes_of_class($urandom_range(0, CLASS_CNT - 1));
  endfunction

  task automatic free_live_block();
    int                 idx;
    logic [ADDR_W-1:0]  addr;
    logic [BYTES_W-1:0] nbytes;
    idx    = $urandom_range(0, live_blocks.size() - 1);
    addr   = live_blocks[idx].addr;
    nbytes = live_blocks[idx].nbytes;
    // keep it now and then so it gets freed twice
    if ($urandom_range(99) >= 10)
      live_blocks.delete(idx);
    if ($urandom_range(99) < 10)
      addr = addr + ADDR_W'($urandom_range(1, GRAIN - 1));
    issue_request(scba_pkg::OPC_FREE, nbytes, addr);
  endtask

  task automatic mixed_beat();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      issue_request(scba_pkg::OPC_ALLOC, pick_size(), ADDR_W'($urandom_range(0, 262143)));
    else if (r < 75) begin
      if (live_blocks.size() != 0 && $urandom_range(99) < 80)
        free_live_block();
      else
        issue_request(scba_pkg::OPC_FREE, pick_size(), ADDR_W'($urandom_range(0, 262143)));
    end else if (r < 82)
      issue_request($urandom_range(0, 1) ? scba_pkg::OPC_FREE : scba_pkg::OPC_ALLOC,
                    BYTES_W'($urandom_range(SMALL_MAX + 1, 65535)),
                    ADDR_W'($urandom_range(0, 262143)));
    else if (r < 89)
      issue_request(OPC_W'($urandom_range(0, 3)), BYTES_W'($urandom_range(0, 65535)),
                    ADDR_W'($urandom_range(0, 262143)));
    else if (r < 94)
      issue_request(OPC_UNUSED, BYTES_W'($urandom_range(0, 65535)),
                    ADDR_W'($urandom_range(0, 262143)));
    else if (r < 97)
      issue_request(scba_pkg::OPC_COLLECT, BYTES_W'($urandom_range(0, 65535)),
                    ADDR_W'($urandom_range(0, 262143)));
    else
      issue_request(scba_pkg::OPC_ALLOC, $urandom_range(0, 1) ? BYTES_W'(SMALL_MAX) : '0, '0);
  endtask

  task automatic test_directed();
    write_chunk_limit(7'd64);
    issue_request(scba_pkg::OPC_ALLOC, 16'd0, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd1, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd8, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd9, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd513, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'hFFFF, '1);
    issue_request(scba_pkg::OPC_FREE, 16'hFFFF, '1);
    // misaligned free lands on the block base
    issue_request(scba_pkg::OPC_FREE, 16'd512, 18'd8197);
    // foreign free at the very top of the heap
    issue_request(scba_pkg::OPC_FREE, 16'd512, 18'h3FFFF);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    // same block freed twice comes back twice
    issue_request(scba_pkg::OPC_FREE, 16'd505, 18'd8192);
    issue_request(scba_pkg::OPC_FREE, 16'd512, 18'd8192);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(OPC_UNUSED, 16'hFFFF, '1);
    issue_request(scba_pkg::OPC_COLLECT, '0, '0);
    write_chunk_limit(7'd0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd4, '0);
    write_chunk_limit(7'd1);
    issue_request(scba_pkg::OPC_ALLOC, 16'd512, '0);
    issue_request(scba_pkg::OPC_ALLOC, 16'd16, '0);
    issue_request(scba_pkg::OPC_COLLECT, '1, '1);
  endtask

  task automatic test_mixed_traffic(input logic [CFG_W-1:0] limit, input int src_pct,
                                    input int sink_pct, input int count);
    write_chunk_limit(limit);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    issue_request(scba_pkg::OPC_COLLECT, '0, '0);
    for (int i = 0; i < count; i++)
      mixed_beat();
  endtask

  // alloc-heavy run that claims every chunk the limit allows
  task automatic test_chunk_fill(input logic [CFG_W-1:0] limit, input int src_pct,
                                 input int sink_pct, input int count);
    write_chunk_limit(limit);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    issue_request(scba_pkg::OPC_COLLECT, '0, '0);
    for (int i = 0; i < count; i++) begin
      if (live_blocks.size() != 0 && $urandom_range(99) < 10)
        free_live_block();
      else if ($urandom_range(99) < 50)
        issue_request(scba_pkg::OPC_ALLOC, bytes_of_class(CLASS_CNT - 1), '0);
      else
        issue_request(scba_pkg::OPC_ALLOC,
                      bytes_of_class($urandom_range(0, CLASS_CNT - 1)), '0);
    end
  endtask

  always @(posedge clk_i)
    m_axis_tready_i <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (alloc_results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d addr %h",
                 $time, m_axis_tuser_o, m_axis_tdata_o[ADDR_W-1:0]);
        mismatch_count++;
      end else begin
        arrived_want = alloc_results_q.pop_front();
        if (m_axis_tuser_o !== arrived_want.sts) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, arrived_want.sts, m_axis_tuser_o);
          mismatch_count++;
        end
        if (m_axis_tdata_o[ADDR_W-1:0] !== arrived_want.addr) begin
          $display("%0t: block_address mismatch: expected %h actual %h",
                   $time, arrived_want.addr, m_axis_tdata_o[ADDR_W-1:0]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    drop_lists_and_chunks();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_mixed_traffic(7'd64, 0, 0, 150);
    test_mixed_traffic(7'd1, 65, 0, 150);
    test_chunk_fill(7'd127, 0, 65, 240);
    test_mixed_traffic(7'd0, 13, 13, 100);
    test_mixed_traffic(7'd5, 65, 0, 150);
    test_mixed_traffic(7'd64, 0, 65, 160);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb_size_class_block_allocator: clean");
    else
      $display("tb_size_class_block_allocator: errors");
    $finish;
  end

endmodule

`default_nettype wire
